>>> rtl/core/qvr_pkg.sv
// Shared types, constants and the arctangent table for the vector rotator.
package qvr_pkg;

    localparam int VEC_W        = 32;
    localparam int QUAT_W       = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TURN_W       = 32;
    localparam int TRIG_W       = 34;
    localparam int COEF_W       = TRIG_W;
    localparam int MSUM_W       = 2 * QUAT_W + 2;
    localparam int SHIFT_QUAT   = QUAT_W - 1;
    localparam int SHIFT_TRIG   = 30;
    localparam int MENT_W       = MSUM_W - SHIFT_QUAT;
    localparam int PROD_W       = VEC_W + COEF_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int STEP_W       = 5;
    localparam int OUT_STAGE    = CORDIC_STEPS + 2;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [MENT_W-1:0] ment_t;

    localparam trig_t CORDIC_GAIN = TRIG_W'(652032874);
    localparam vec_t  VEC_MAX     = {1'b0, {(VEC_W-1){1'b1}}};
    localparam vec_t  VEC_MIN     = {1'b1, {(VEC_W-1){1'b0}}};

    // Operation codes of the opcode field
    localparam logic OP_TO_FIXED = 1'b0;
    localparam logic OP_TO_LOCAL = 1'b1;

    typedef struct packed {
        trig_t x;
        trig_t y;
        trig_t z;
    } cordic_t;

    typedef struct packed {
        logic op;
        logic mode;
        logic neg;
        vec_t vx;
        vec_t vy;
        vec_t vz;
    } side_t;

    // Arctangent of 2^-i in turn units where 2^31 is pi
    function automatic trig_t atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return trig_t'(v);
        end
    endfunction

endpackage

>>> rtl/core/qvr_cordic_stage.sv
// One registered CORDIC rotation step.
module qvr_cordic_stage (
    input  logic                      clk,
    input  logic                      en,
    input  logic [qvr_pkg::STEP_W-1:0] step,
    input  qvr_pkg::cordic_t          din,
    output qvr_pkg::cordic_t          dout
);
    import qvr_pkg::*;

    trig_t   xs;
    trig_t   ys;
    cordic_t dout_next;
    cordic_t dout_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        xs = $signed(din.x) >>> step;
        ys = $signed(din.y) >>> step;
        if (!din.z[TRIG_W-1])
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - atan_turn(step);
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + atan_turn(step);
        end
    end

    // Hold while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/qvr_matrix.sv
// Rotation matrix from a quaternion, two register stages.
module qvr_matrix (
    input  logic          clk,
    input  logic          en,
    input  qvr_pkg::quat_t qw,
    input  qvr_pkg::quat_t qi,
    input  qvr_pkg::quat_t qj,
    input  qvr_pkg::quat_t qk,
    output qvr_pkg::ment_t m [3][3]
);
    import qvr_pkg::*;

    typedef logic signed [2*QUAT_W-1:0] qprod_t;
    typedef logic signed [MSUM_W-1:0]   msum_t;

    qprod_t ww_reg, ii_reg, jj_reg, kk_reg;
    qprod_t ij_reg, wk_reg, ik_reg, wj_reg, jk_reg, wi_reg;
    msum_t  e [3][3];
    ment_t  m_reg [3][3];

    function automatic ment_t rnd(input msum_t v);
        msum_t t;
        begin
            t = v + msum_t'(1 << (SHIFT_QUAT - 1));
            return t[MSUM_W-1:SHIFT_QUAT];
        end
    endfunction

    function automatic msum_t ext(input qprod_t v);
        return msum_t'(v);
    endfunction

    // Form all pairwise products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            ii_reg <= qi * qi;
            jj_reg <= qj * qj;
            kk_reg <= qk * qk;
            ij_reg <= qi * qj;
            wk_reg <= qw * qk;
            ik_reg <= qi * qk;
            wj_reg <= qw * qj;
            jk_reg <= qj * qk;
            wi_reg <= qw * qi;
        end
    end

    // Combine products into matrix entries
    always_comb
    begin
        e[0][0] = ext(ww_reg) + ext(ii_reg) - ext(jj_reg) - ext(kk_reg);
        e[1][1] = ext(ww_reg) - ext(ii_reg) + ext(jj_reg) - ext(kk_reg);
        e[2][2] = ext(ww_reg) - ext(ii_reg) - ext(jj_reg) + ext(kk_reg);
        e[0][1] = (ext(ij_reg) - ext(wk_reg)) <<< 1;
        e[0][2] = (ext(ik_reg) + ext(wj_reg)) <<< 1;
        e[1][0] = (ext(ij_reg) + ext(wk_reg)) <<< 1;
        e[1][2] = (ext(jk_reg) - ext(wi_reg)) <<< 1;
        e[2][0] = (ext(ik_reg) - ext(wj_reg)) <<< 1;
        e[2][1] = (ext(jk_reg) + ext(wi_reg)) <<< 1;
    end

    // Round entries to Q.15
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    m_reg[r][c] <= rnd(e[r][c]);
                end
            end
        end
    end

    assign m = m_reg;

endmodule

>>> rtl/core/qvr_lane.sv
// One output component: three products, rounded sum and saturation.
module qvr_lane (
    input  logic          clk,
    input  logic          en,
    input  logic          trig_sel,
    input  qvr_pkg::coef_t coef [3],
    input  qvr_pkg::vec_t  vec [3],
    output qvr_pkg::vec_t  result
);
    import qvr_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    prod_t prod_reg [3];
    logic  sel_reg;
    acc_t  acc;
    acc_t  shifted;
    vec_t  sat;
    vec_t  result_reg;

    // Multiply each coefficient by its component
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg <= trig_sel;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= coef[k] * vec[k];
            end
        end
    end

    // Sum, round half up and clamp
    always_comb
    begin
        acc = acc_t'(prod_reg[0]) + acc_t'(prod_reg[1]) + acc_t'(prod_reg[2]);
        if (sel_reg)
        begin
            shifted = (acc + acc_t'(64'sd1 <<< (SHIFT_TRIG - 1))) >>> SHIFT_TRIG;
        end
        else
        begin
            shifted = (acc + acc_t'(64'sd1 <<< (SHIFT_QUAT - 1))) >>> SHIFT_QUAT;
        end
        if (shifted > acc_t'(VEC_MAX))
        begin
            sat = VEC_MAX;
        end
        else if (shifted < acc_t'(VEC_MIN))
        begin
            sat = VEC_MIN;
        end
        else
        begin
            sat = shifted[VEC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= sat;
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/core/quaternion_vector_rotate_top.sv
// Top level of the quaternion / planar vector rotator.
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_data (two_d_mode)
//  in      | in        | in_valid/in_stall  | opcode, vec_x..z, quat_w..k
//  out     | out       | out_valid/stall    | rot_x, rot_y, rot_z
//
// One transaction per cycle unless the output stalls; the path is the input
// register, one register per CORDIC step, and the product and sum stages of the lanes.
// The quaternion matrix is built in two stages and delayed to meet the CORDIC.
// Reset clears the valid bits and the mode register only.
// A stalled output with valid data freezes the whole pipeline and raises in_stall.
module quaternion_vector_rotate_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          opcode,
    input  qvr_pkg::vec_t  vec_x,
    input  qvr_pkg::vec_t  vec_y,
    input  qvr_pkg::vec_t  vec_z,
    input  qvr_pkg::quat_t quat_w,
    input  qvr_pkg::quat_t quat_i,
    input  qvr_pkg::quat_t quat_j,
    input  qvr_pkg::quat_t quat_k,
    output logic          out_valid,
    input  logic          out_stall,
    output qvr_pkg::vec_t  rot_x,
    output qvr_pkg::vec_t  rot_y,
    output qvr_pkg::vec_t  rot_z
);
    import qvr_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic        mode_reg;
    logic        adv;
    logic        valid_reg [OUT_STAGE+1];
    side_t       side_reg [OUT_STAGE+1];
    side_t       side_in;
    quat_t       quat_reg [4];
    trig_t       z0_reg;
    logic [TURN_W-1:0] ang;
    logic [TURN_W-1:0] ang_rot;
    cordic_t     cor [N+1];
    ment_t       mat_q [3][3];
    ment_t       mat_dly_reg [N-2][3][3];
    ment_t       mat [3][3];
    trig_t       cos_v;
    trig_t       sin_v;
    coef_t       coef [3][3];
    vec_t        vec [3];
    vec_t        res [3];

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Advance the whole pipeline unless the output is held
    assign adv      = !(valid_reg[OUT_STAGE] && out_stall);
    assign in_stall = !adv;

    // Fold the angle into the right half plane
    always_comb
    begin
        ang     = {quat_w, {(TURN_W-QUAT_W){1'b0}}};
        ang_rot = ang + {2'b01, {(TURN_W-2){1'b0}}};
        side_in.op   = opcode;
        side_in.mode = mode_reg;
        side_in.neg  = ang_rot[TURN_W-1];
        side_in.vx   = vec_x;
        side_in.vy   = vec_y;
        side_in.vz   = vec_z;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= OUT_STAGE; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= OUT_STAGE; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Payload and sideband shift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            quat_reg[0] <= quat_w;
            quat_reg[1] <= quat_i;
            quat_reg[2] <= quat_j;
            quat_reg[3] <= quat_k;
            if (side_in.neg)
            begin
                z0_reg <= trig_t'($signed(ang ^ {1'b1, {(TURN_W-1){1'b0}}}));
            end
            else
            begin
                z0_reg <= trig_t'($signed(ang));
            end
            for (int k = 1; k <= OUT_STAGE; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // CORDIC chain
    always_comb
    begin
        cor[0].x = CORDIC_GAIN;
        cor[0].y = '0;
        cor[0].z = z0_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        qvr_cordic_stage u_stage (
            .clk  (clk),
            .en   (adv),
            .step (STEP_W'(i)),
            .din  (cor[i]),
            .dout (cor[i+1])
        );
    end

    // Quaternion matrix and its delay to the CORDIC output
    qvr_matrix u_matrix (
        .clk (clk),
        .en  (adv),
        .qw  (quat_reg[0]),
        .qi  (quat_reg[1]),
        .qj  (quat_reg[2]),
        .qk  (quat_reg[3]),
        .m   (mat_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_dly_reg[0] <= mat_q;
            for (int k = 1; k < N - 2; k++)
            begin
                mat_dly_reg[k] <= mat_dly_reg[k-1];
            end
        end
    end

    assign mat = mat_dly_reg[N-3];

    // Select lane coefficients
    always_comb
    begin
        cos_v = side_reg[N].neg ? -cor[N].x : cor[N].x;
        sin_v = side_reg[N].neg ? -cor[N].y : cor[N].y;
        vec[0] = side_reg[N].vx;
        vec[1] = side_reg[N].vy;
        vec[2] = side_reg[N].vz;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (side_reg[N].op == OP_TO_LOCAL)
                begin
                    coef[r][c] = coef_t'(mat[c][r]);
                end
                else
                begin
                    coef[r][c] = coef_t'(mat[r][c]);
                end
            end
        end
        if (side_reg[N].mode)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    coef[r][c] = '0;
                end
            end
            coef[0][0] = cos_v;
            coef[1][1] = cos_v;
            if (side_reg[N].op == OP_TO_LOCAL)
            begin
                coef[0][1] = sin_v;
                coef[1][0] = -sin_v;
            end
            else
            begin
                coef[0][1] = -sin_v;
                coef[1][0] = sin_v;
            end
        end
    end

    // Output lanes
    for (genvar r = 0; r < 3; r++)
    begin : g_lane
        qvr_lane u_lane (
            .clk      (clk),
            .en       (adv),
            .trig_sel (side_reg[N].mode),
            .coef     (coef[r]),
            .vec      (vec),
            .result   (res[r])
        );
    end

    // Merge lane results onto the output channel
    assign out_valid = valid_reg[OUT_STAGE];
    assign rot_x     = res[0];
    assign rot_y     = res[1];
    assign rot_z     = res[2];

    // Planar transactions leave z at zero
    a_planar_z_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_reg[OUT_STAGE].mode |-> rot_z == '0)
        else $error("planar result has nonzero z");

    // Planar CORDIC output stays strictly within +/-2^31
    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] && side_reg[N].mode |->
        (cor[N].x < trig_t'(64'sd2147483648) && cor[N].x > -trig_t'(64'sd2147483648)
         && cor[N].y < trig_t'(64'sd2147483648)
         && cor[N].y > -trig_t'(64'sd2147483648)))
        else $error("CORDIC output out of range");

endmodule
